FILE: src/cbbm_pkg.sv
// Package for the cursor byte/bit map: store geometry, op and status codes,
// register indexes and the transfer and control structs.
// No dependencies; cbbm_alu, cursor_byte_bit_map and cbbm_checker import it.
package cbbm_pkg;

    // Store geometry
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     SIZE_RESET = 7'd64;

    // Op codes
    localparam logic [3:0] OP_SELECT      = 4'd0;
    localparam logic [3:0] OP_REPLACE     = 4'd1;
    localparam logic [3:0] OP_SET_IF_ZERO = 4'd2;
    localparam logic [3:0] OP_ZERO_BYTE   = 4'd3;
    localparam logic [3:0] OP_GET_BYTE    = 4'd4;
    localparam logic [3:0] OP_BIT_SET     = 4'd5;
    localparam logic [3:0] OP_BIT_CLEAR   = 4'd6;
    localparam logic [3:0] OP_BIT_TOGGLE  = 4'd7;
    localparam logic [3:0] OP_BIT_GET     = 4'd8;
    localparam logic [3:0] OP_CLEAR_ALL   = 4'd9;

    // Status codes
    localparam logic [1:0] STATUS_OK            = 2'd0;
    localparam logic [1:0] STATUS_BYTE_NOT_ZERO = 2'd1;
    localparam logic [1:0] STATUS_BIT_NOT_ZERO  = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [5:0] x_coord;
        logic [5:0] y_coord;
        logic [7:0] byte_value;
        logic [2:0] bit_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       bit_value;
        logic       hit;
        logic [1:0] status;
    } out_item_t;

    // Outcome of one op, from the modify unit to the sequencer
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
        logic       cursor_load;
        logic       clear_start;
        out_item_t  result;
    } alu_res_t;

endpackage

FILE: src/cbbm_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module cbbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/cbbm_alu.sv
// Modify unit: works out the new byte, write enable, cursor load and result
// of one op from the byte read out of the store. Depends on cbbm_pkg.
module cbbm_alu
    import cbbm_pkg::*;
(
    input  in_item_t   item,
    input  logic [7:0] rdata,
    input  logic       sel_in,
    input  logic       cur_in,
    output alu_res_t   res
);

    logic [7:0] mask;
    logic       bit_now;

    assign mask    = 8'b1 << item.bit_index;
    assign bit_now = rdata[item.bit_index];

    always_comb begin
        res         = '0;
        res.wr_data = rdata;
        unique case (item.op) inside
            OP_SELECT: begin
                if (sel_in) begin
                    res.cursor_load = 1'b1;
                    res.result.hit  = 1'b1;
                end
            end
            OP_CLEAR_ALL: begin
                res.clear_start = 1'b1;
                res.result.hit  = 1'b1;
            end
            [OP_REPLACE:OP_BIT_GET]: begin
                // Byte and bit ops act only with the cursor inside
                if (cur_in) begin
                    res.result.hit = 1'b1;
                    unique case (item.op)
                        OP_REPLACE: begin
                            res.wr_en   = 1'b1;
                            res.wr_data = item.byte_value;
                        end
                        OP_SET_IF_ZERO: begin
                            if (rdata != 8'd0) begin
                                res.result.status = STATUS_BYTE_NOT_ZERO;
                            end else begin
                                res.wr_en   = 1'b1;
                                res.wr_data = item.byte_value;
                            end
                        end
                        OP_ZERO_BYTE: begin
                            res.wr_en   = 1'b1;
                            res.wr_data = 8'd0;
                        end
                        OP_GET_BYTE: begin
                            res.result.read_byte = rdata;
                        end
                        OP_BIT_SET: begin
                            if (bit_now) begin
                                res.result.status = STATUS_BIT_NOT_ZERO;
                            end else begin
                                res.wr_en   = 1'b1;
                                res.wr_data = rdata | mask;
                            end
                        end
                        OP_BIT_CLEAR: begin
                            res.wr_en   = 1'b1;
                            res.wr_data = rdata & ~mask;
                        end
                        OP_BIT_TOGGLE: begin
                            res.wr_en   = 1'b1;
                            res.wr_data = rdata ^ mask;
                        end
                        OP_BIT_GET: begin
                            res.result.bit_value = bit_now;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // Unused op codes give an all-zero result
            end
        endcase
    end

endmodule

FILE: src/cursor_byte_bit_map.sv
// Cursor byte/bit map: 64 x 64 byte store in one synchronous RAM, a cursor,
// and the op sequencer. Depends on cbbm_pkg, cbbm_ram and cbbm_alu.
//
// Usage:
//   Ops arrive on the s_ channel (s_valid/s_ready, payload s_item) and each
//   gives exactly one result on the m_ channel (m_valid/m_ready, m_item).
//   The size registers are written through cfg_we/cfg_index/cfg_wdata while
//   the block is idle (a rule for the user; the block does not enforce it);
//   index 0 is the column count, index 1 the row count. Operation: an op
//   first reads the byte under the cursor from the store RAM, then modifies
//   it, writes it back and loads the result register in its execute state;
//   the next op is taken only after that. The single RAM port is the limit.
//   clear_all delivers its result at once, then sweeps the RAM one entry a
//   cycle, with s_ready low until all 4096 entries are cleared.
//   Reset clears the cursor, sets both sizes to 64 and runs the same sweep
//   over all 4096 entries before the first op is taken.
//   The result register decouples the channels: an op is taken while the
//   previous result waits, and if that result is still not taken when the
//   next one is ready, the op holds in its execute cycle with s_ready low.
module cursor_byte_bit_map
    import cbbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam logic [1:0] FSM_CLEAR = 2'd0;
    localparam logic [1:0] FSM_IDLE  = 2'd1;
    localparam logic [1:0] FSM_EXEC  = 2'd2;

    logic [1:0]        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [5:0]        cur_col_reg, cur_col_next;
    logic [5:0]        cur_row_reg, cur_row_next;
    logic [CFG_W-1:0]  width_reg, width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              accept;
    logic              done;
    logic              sel_in;
    logic              cur_in;
    logic [ADDR_W-1:0] cur_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    alu_res_t          alu_res;

    assign s_ready = (state_reg == FSM_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign accept = s_valid && s_ready;
    assign done   = (state_reg == FSM_EXEC) && (!m_valid_reg || m_ready);

    // Bounds checks against the configured size
    assign sel_in = ({1'b0, item_reg.x_coord} < width_reg)
                 && ({1'b0, item_reg.y_coord} < height_reg);
    assign cur_in = ({1'b0, cur_col_reg} < width_reg)
                 && ({1'b0, cur_row_reg} < height_reg);

    assign cur_addr = ADDR_W'(cur_row_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(cur_col_reg);

    // Store port: sweep address while clearing, cursor address otherwise
    assign ram_we    = (state_reg == FSM_CLEAR) || (done && alu_res.wr_en);
    assign ram_addr  = (state_reg == FSM_CLEAR) ? clr_cnt_reg : cur_addr;
    assign ram_wdata = (state_reg == FSM_CLEAR) ? 8'd0 : alu_res.wr_data;

    cbbm_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cbbm_alu u_alu (
        .item   (item_reg),
        .rdata  (ram_rdata),
        .sel_in (sel_in),
        .cur_in (cur_in),
        .res    (alu_res)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            FSM_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (done) begin
                    if (alu_res.clear_start) begin
                        state_next   = FSM_CLEAR;
                        clr_cnt_next = '0;
                    end else begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Hold the accepted op for its execute cycle
    assign item_next = accept ? s_item : item_reg;

    // Move the cursor on a select that hits
    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (done && alu_res.cursor_load) begin
            cur_col_next = item_reg.x_coord;
            cur_row_next = item_reg.y_coord;
        end
    end

    // Size registers
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_next  = cfg_wdata;
                REG_HEIGHT: height_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Result register: load on completion, drop on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (done) begin
            m_valid_next = 1'b1;
            m_item_next  = alu_res.result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_CLEAR;
            clr_cnt_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_item_reg <= m_item_next;
    end

endmodule

FILE: src/cbbm_checker.sv
// Port-level checker for the cursor byte/bit map, bound to the top level.
// Depends on cbbm_pkg and cursor_byte_bit_map.
module cbbm_port_checks
    import cbbm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // Hold a stalled result
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // Reset starts the store sweep, so no op is taken right after it
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("op taken during reset sweep");

    // An accepted op always passes through the execute state, so ops are never taken back to back
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("op taken back to back");

    // A flagged status or read data only comes with a hit
    a_status_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status != STATUS_OK || m_item.read_byte != 8'd0
                    || m_item.bit_value) |-> m_item.hit)
        else $error("status or data without hit");

endmodule

bind cursor_byte_bit_map cbbm_port_checks u_cbbm_port_checks (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
